// ===== hw/rtl/sh_pkg.sv =====
`timescale 1ns / 1ps

package sh_pkg;

  // round slots in the pipeline, one per possible round
  localparam int unsigned MaxCompRounds = 4;
  localparam int unsigned MaxFinRounds  = 8;

  // every round is split over two register stages
  localparam int unsigned Phase2Start = 2 * MaxCompRounds;
  localparam int unsigned FinStart    = 4 * MaxCompRounds;
  localparam int unsigned HalfStages  = FinStart + 2 * MaxFinRounds;

  localparam int unsigned CompCntW = 3;
  localparam int unsigned FinCntW  = 4;

  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 5;

  localparam logic [63:0] SipC0 = 64'h736f6d6570736575;
  localparam logic [63:0] SipC1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SipC2 = 64'h6c7967656e657261;
  localparam logic [63:0] SipC3 = 64'h7465646279746573;

  localparam logic [7:0]  MsgLenBytes = 8'd12;
  localparam int unsigned LenShift    = 56;
  localparam logic [63:0] FinalXor    = 64'hff;

  localparam logic [CompCntW-1:0] CompRoundsRst = CompCntW'(2);
  localparam logic [FinCntW-1:0]  FinRoundsRst  = FinCntW'(4);

  typedef enum logic [1:0] {
    RegKeyLow     = 2'd0,
    RegKeyHigh    = 2'd1,
    RegCompRounds = 2'd2,
    RegFinRounds  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  typedef struct packed {
    logic [31:0] word_c;
    logic [31:0] word_b;
    logic [31:0] word_a;
  } msg_t;

  typedef struct packed {
    logic   valid;
    lanes_t lanes;
    msg_t   msg;
  } stage_t;

  typedef struct packed {
    logic advance;
    logic round_en;
    logic second_half;
  } stage_ctrl_t;

  typedef struct packed {
    logic [63:0]         key_low;
    logic [63:0]         key_high;
    logic [CompCntW-1:0] comp_rounds;
    logic [FinCntW-1:0]  fin_rounds;
  } cfg_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] first_block(input msg_t m);
    first_block = {m.word_b, m.word_a};
  endfunction

  function automatic logic [63:0] last_block(input msg_t m);
    last_block = (64'(MsgLenBytes) << LenShift) | 64'(m.word_c);
  endfunction

  // one half of a sipround: a single 64-bit add level per lane pair
  function automatic lanes_t half_round(input lanes_t s, input logic second_half);
    lanes_t r;
    r = s;
    if (!second_half) begin
      r.v0 = s.v0 + s.v1;
      r.v1 = rotl(s.v1, 13) ^ r.v0;
      r.v0 = rotl(r.v0, 32);
      r.v2 = s.v2 + s.v3;
      r.v3 = rotl(s.v3, 16) ^ r.v2;
    end else begin
      r.v0 = s.v0 + s.v3;
      r.v3 = rotl(s.v3, 21) ^ r.v0;
      r.v2 = s.v2 + s.v1;
      r.v1 = rotl(s.v1, 17) ^ r.v2;
      r.v2 = rotl(r.v2, 32);
    end
    half_round = r;
  endfunction

endpackage

// ===== hw/rtl/sh_round_stage.sv =====
`timescale 1ns / 1ps

module sh_round_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sh_pkg::stage_ctrl_t ctrl_i,
  input  sh_pkg::stage_t     stage_i,
  output sh_pkg::stage_t     stage_o
);

  logic           valid_q;
  sh_pkg::lanes_t lanes_d, lanes_q;
  sh_pkg::msg_t   msg_q;

  always_comb begin
    if (ctrl_i.round_en) begin
      lanes_d = sh_pkg::half_round(stage_i.lanes, ctrl_i.second_half);
    end else begin
      lanes_d = stage_i.lanes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      lanes_q <= lanes_d;
      msg_q   <= stage_i.msg;
    end
  end

  assign stage_o = '{valid: valid_q, lanes: lanes_q, msg: msg_q};

endmodule

// ===== hw/rtl/sh_cfg_regs.sv =====
`timescale 1ns / 1ps

module sh_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sh_pkg::CfgAddrW-1:0] paddr,
  input  logic [sh_pkg::CfgDataW-1:0] pwdata,
  output logic [sh_pkg::CfgDataW-1:0] prdata,
  output logic                        pready,
  output sh_pkg::cfg_t                cfg_o
);

  sh_pkg::cfg_t     cfg_q;
  sh_pkg::cfg_reg_e reg_sel;
  logic             wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  // registers sit on 8-byte boundaries
  assign reg_sel = sh_pkg::cfg_reg_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_low     <= '0;
      cfg_q.key_high    <= '0;
      cfg_q.comp_rounds <= sh_pkg::CompRoundsRst;
      cfg_q.fin_rounds  <= sh_pkg::FinRoundsRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        sh_pkg::RegKeyLow:     cfg_q.key_low     <= pwdata;
        sh_pkg::RegKeyHigh:    cfg_q.key_high    <= pwdata;
        sh_pkg::RegCompRounds: cfg_q.comp_rounds <= pwdata[sh_pkg::CompCntW-1:0];
        sh_pkg::RegFinRounds:  cfg_q.fin_rounds  <= pwdata[sh_pkg::FinCntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      sh_pkg::RegKeyLow:     prdata = cfg_q.key_low;
      sh_pkg::RegKeyHigh:    prdata = cfg_q.key_high;
      sh_pkg::RegCompRounds: prdata = sh_pkg::CfgDataW'(cfg_q.comp_rounds);
      sh_pkg::RegFinRounds:  prdata = sh_pkg::CfgDataW'(cfg_q.fin_rounds);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/siphash_three_word_hash.sv =====
`timescale 1ns / 1ps

// Keyed SipHash of a 12-byte message given as three 32-bit words, one 64-bit hash per
// message. A new message is taken every cycle unless the skid register holds a result.
// Each sipround is split over two register stages; there is a stage pair for every
// possible round (4 + 4 compression, 8 finalization), and rounds beyond the configured
// counts pass their stage unchanged, so every hash passes the same stages whatever the
// round counts. The longest path per stage is one 64-bit add followed by a rotate and
// xor. Compression counts above 4 run as 4, finalization counts above 8 as 8. The
// pipeline only stalls when both the output register and the skid register behind it
// hold results. The user must write key and round counts through the register port only
// while no word is in flight; the block itself does not enforce this.
module siphash_three_word_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // word_a [31:0], word_b [63:32], word_c [95:64]
  input  logic [sh_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // hash_value [63:0]
  output logic [sh_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sh_pkg::CfgAddrW-1:0] paddr,
  input  logic [sh_pkg::CfgDataW-1:0] pwdata,
  output logic [sh_pkg::CfgDataW-1:0] prdata,
  output logic                        pready
);

  sh_pkg::cfg_t   cfg;
  sh_pkg::stage_t st [0:sh_pkg::HalfStages];

  logic                          advance;
  logic [sh_pkg::CompCntW-1:0]   comp_sat;
  logic [sh_pkg::FinCntW-1:0]    fin_sat;
  logic [sh_pkg::MaxCompRounds-1:0] comp_en;
  logic [sh_pkg::MaxFinRounds-1:0]  fin_en;

  logic           in_valid_q;
  sh_pkg::lanes_t in_lanes_d, in_lanes_q;
  sh_pkg::msg_t   in_msg_d, in_msg_q;

  logic                        push;
  logic [sh_pkg::OutDataW-1:0] hash_d;
  logic                        out_valid_q, skid_valid_q;
  logic [sh_pkg::OutDataW-1:0] out_q, skid_q;

  sh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign comp_sat = (cfg.comp_rounds > sh_pkg::CompCntW'(sh_pkg::MaxCompRounds)) ?
                    sh_pkg::CompCntW'(sh_pkg::MaxCompRounds) : cfg.comp_rounds;
  assign fin_sat  = (cfg.fin_rounds > sh_pkg::FinCntW'(sh_pkg::MaxFinRounds)) ?
                    sh_pkg::FinCntW'(sh_pkg::MaxFinRounds) : cfg.fin_rounds;

  for (genvar r = 0; r < sh_pkg::MaxCompRounds; r++) begin : g_comp_en
    assign comp_en[r] = sh_pkg::CompCntW'(r) < comp_sat;
  end
  for (genvar r = 0; r < sh_pkg::MaxFinRounds; r++) begin : g_fin_en
    assign fin_en[r] = sh_pkg::FinCntW'(r) < fin_sat;
  end

  // the whole pipe moves unless the skid register is holding a word
  assign advance       = !skid_valid_q;
  assign s_axis_tready = advance;

  // entry stage: key into the lanes, first block into v3
  always_comb begin
    in_msg_d.word_a = s_axis_tdata[31:0];
    in_msg_d.word_b = s_axis_tdata[63:32];
    in_msg_d.word_c = s_axis_tdata[95:64];
    in_lanes_d.v0   = sh_pkg::SipC0 ^ cfg.key_low;
    in_lanes_d.v1   = sh_pkg::SipC1 ^ cfg.key_high;
    in_lanes_d.v2   = sh_pkg::SipC2 ^ cfg.key_low;
    in_lanes_d.v3   = sh_pkg::SipC3 ^ cfg.key_high ^ sh_pkg::first_block(in_msg_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_lanes_q <= in_lanes_d;
      in_msg_q   <= in_msg_d;
    end
  end

  assign st[0] = '{valid: in_valid_q, lanes: in_lanes_q, msg: in_msg_q};

  for (genvar k = 0; k < sh_pkg::HalfStages; k++) begin : g_half
    sh_pkg::stage_t      pre;
    sh_pkg::stage_ctrl_t ctrl;
    logic                en;

    // xors that sit between the phases go ahead of the first half-round
    if (k == sh_pkg::Phase2Start) begin : g_xor_mid
      always_comb begin
        pre          = st[k];
        pre.lanes.v0 = st[k].lanes.v0 ^ sh_pkg::first_block(st[k].msg);
        pre.lanes.v3 = st[k].lanes.v3 ^ sh_pkg::last_block(st[k].msg);
      end
    end else if (k == sh_pkg::FinStart) begin : g_xor_fin
      always_comb begin
        pre          = st[k];
        pre.lanes.v0 = st[k].lanes.v0 ^ sh_pkg::last_block(st[k].msg);
        pre.lanes.v2 = st[k].lanes.v2 ^ sh_pkg::FinalXor;
      end
    end else begin : g_xor_none
      assign pre = st[k];
    end

    if (k < sh_pkg::Phase2Start) begin : g_en_c1
      assign en = comp_en[k/2];
    end else if (k < sh_pkg::FinStart) begin : g_en_c2
      assign en = comp_en[(k - sh_pkg::Phase2Start)/2];
    end else begin : g_en_fin
      assign en = fin_en[(k - sh_pkg::FinStart)/2];
    end

    assign ctrl = '{advance: advance, round_en: en, second_half: 1'((k % 2) == 1)};

    sh_round_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .stage_i (pre),
      .stage_o (st[k+1])
    );
  end

  assign push   = advance && st[sh_pkg::HalfStages].valid;
  assign hash_d = (st[sh_pkg::HalfStages].lanes.v0 ^ st[sh_pkg::HalfStages].lanes.v1) ^
                  (st[sh_pkg::HalfStages].lanes.v2 ^ st[sh_pkg::HalfStages].lanes.v3);

  // output register with a skid word behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : hash_d;
    end else if (push) begin
      skid_q <= hash_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready && push))
    else $error("skid filled without a stalled output");

  a_push_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !out_valid_q) |=> (m_axis_tvalid && m_axis_tdata == $past(hash_d)))
    else $error("finished word did not reach the output");

  a_no_push_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push && !s_axis_tready)
    else $error("pipeline moved while skid word held");

endmodule
